// ===== design/mac_pkg.sv =====
// Shared types and constants for the mesh element area and centroid core.
`timescale 1ns / 1ps
package mac_pkg;

  // Field layout of one input item
  localparam int FW     = 32;          // width of one coordinate field
  localparam int VTX_N  = 4;           // vertices per item
  localparam int KIND_W = 8;
  localparam int IN_DATA_W = VTX_N * 2 * FW;

  // Arithmetic widths
  localparam int CW   = 32;            // coordinate width in use
  localparam int DW   = CW + 1;        // vertex difference
  localparam int PW   = 2 * DW;        // difference product
  localparam int XW   = PW + 1;        // doubled triangle area
  localparam int AW   = XW + 1;        // doubled quad area
  localparam int SW   = CW + 2;        // sum of three coordinates
  localparam int LOW  = SW;            // low slice of a split area operand
  localparam int HW   = XW - LOW;      // high slice of a split area operand
  localparam int PLW  = SW + LOW + 1;  // low partial product
  localparam int PHW  = SW + HW;       // high partial product
  localparam int MW   = XW + SW;       // one weighted sum term
  localparam int NW   = MW + 1;        // centroid numerator
  localparam int EW   = AW + 2;        // centroid denominator (three times doubled area)
  localparam int DVW  = EW + 1;        // doubled divisor magnitude
  localparam int RW   = NW + 2;        // divider remainder
  localparam int QB   = CW;            // quotient bits resolved by the divider
  localparam int NS   = QB + 3;        // divider stages before the output stage
  localparam int AREA_W     = 64;
  localparam int OUT_DATA_W = AREA_W + 2 * CW;
  localparam int VERT_DIV   = 3;       // vertices in a triangle mean

  localparam logic [KIND_W-1:0] KIND_TRI  = KIND_W'(5);
  localparam logic [KIND_W-1:0] KIND_QUAD = KIND_W'(9);

  localparam logic [AREA_W-1:0] AREA_MAX = {1'b0, {(AREA_W-1){1'b1}}};
  localparam logic [AREA_W-1:0] AREA_MIN = {1'b1, {(AREA_W-1){1'b0}}};
  localparam logic [CW-1:0]     CEN_MAX  = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0]     CEN_MIN  = {1'b1, {(CW-1){1'b0}}};

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BADKIND = 2'd1,
    ST_DEGEN   = 2'd2
  } status_e;

  // Differences reduced to doubled triangle areas, plus vertex sums
  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic signed [XW-1:0] d1;
    logic signed [XW-1:0] d2;
    logic signed [SW-1:0] sx1;
    logic signed [SW-1:0] sx2;
    logic signed [SW-1:0] sy1;
    logic signed [SW-1:0] sy2;
  } geom_t;

  // Items that ride alongside the centroid division
  typedef struct packed {
    logic [AREA_W-1:0] area;
    status_e           status;
  } side_t;

  // Numerators and denominator ready for division
  typedef struct packed {
    logic signed [NW-1:0] nx;
    logic signed [NW-1:0] ny;
    logic signed [EW-1:0] den;
    side_t                side;
  } wsum_t;

  // Finished result
  typedef struct packed {
    logic [CW-1:0] cx;
    logic [CW-1:0] cy;
    side_t         side;
  } res_t;

endpackage

// ===== design/mac_geom.sv =====
// Front pipeline: vertex differences, cross products and vertex sums.
`timescale 1ns / 1ps
module mac_geom import mac_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [KIND_W-1:0]    kind_i,
  input  logic [IN_DATA_W-1:0] vtx_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output geom_t                out_o
);

  logic signed [CW-1:0] vx [VTX_N];
  logic signed [CW-1:0] vy [VTX_N];
  logic [2:0] v_q;
  logic [3:0] en;

  // Stage 1: differences to vertex 1 and three-vertex sums
  logic signed [DW-1:0] ex_d [3], ex_q [3];
  logic signed [DW-1:0] ey_d [3], ey_q [3];
  logic signed [SW-1:0] s1_d [4], s1_q [4];
  logic [KIND_W-1:0]    k1_q;
  // Stage 2: four products
  logic signed [PW-1:0] pr_d [4], pr_q [4];
  logic signed [SW-1:0] s2_q [4];
  logic [KIND_W-1:0]    k2_q;
  // Stage 3
  geom_t o_q;

  // Ready ripples back through empty stages
  assign en[3] = out_ready_i;
  assign en[2] = !v_q[2] || en[3];
  assign en[1] = !v_q[1] || en[2];
  assign en[0] = !v_q[0] || en[1];
  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[2];
  assign out_o       = o_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      if (en[1]) v_q[1] <= v_q[0];
      if (en[2]) v_q[2] <= v_q[1];
    end
  end

  // Unpack coordinates
  always_comb begin
    for (int i = 0; i < VTX_N; i++) begin
      vx[i] = vtx_i[2*i*FW +: CW];
      vy[i] = vtx_i[(2*i+1)*FW +: CW];
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ex_d[i] = DW'(vx[i+1]) - DW'(vx[0]);
      ey_d[i] = DW'(vy[i+1]) - DW'(vy[0]);
    end
    s1_d[0] = SW'(vx[0]) + SW'(vx[1]) + SW'(vx[2]);
    s1_d[1] = SW'(vx[0]) + SW'(vx[2]) + SW'(vx[3]);
    s1_d[2] = SW'(vy[0]) + SW'(vy[1]) + SW'(vy[2]);
    s1_d[3] = SW'(vy[0]) + SW'(vy[2]) + SW'(vy[3]);
  end

  // Triangle 1-2-3 and triangle 1-3-4 products
  always_comb begin
    pr_d[0] = PW'(ex_q[0]) * PW'(ey_q[1]);
    pr_d[1] = PW'(ex_q[1]) * PW'(ey_q[0]);
    pr_d[2] = PW'(ex_q[1]) * PW'(ey_q[2]);
    pr_d[3] = PW'(ex_q[2]) * PW'(ey_q[1]);
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      ex_q <= ex_d;
      ey_q <= ey_d;
      s1_q <= s1_d;
      k1_q <= kind_i;
    end
    if (en[1]) begin
      pr_q <= pr_d;
      s2_q <= s1_q;
      k2_q <= k1_q;
    end
    if (en[2]) begin
      o_q.kind <= k2_q;
      o_q.d1   <= XW'(pr_q[0]) - XW'(pr_q[1]);
      o_q.d2   <= XW'(pr_q[2]) - XW'(pr_q[3]);
      o_q.sx1  <= s2_q[0];
      o_q.sx2  <= s2_q[1];
      o_q.sy1  <= s2_q[2];
      o_q.sy2  <= s2_q[3];
    end
  end

endmodule

// ===== design/mac_wmul.sv =====
// Middle pipeline: area-weighted numerators, denominator, area and status.
`timescale 1ns / 1ps
module mac_wmul import mac_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  geom_t in_i,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output wsum_t out_o
);

  logic [2:0] v_q;
  logic [3:0] en;

  // Stage 1: split partial products
  logic signed [SW-1:0]  s_in [4];
  logic signed [XW-1:0]  dd_in [4];
  logic signed [PLW-1:0] plo_d [4], plo_q [4];
  logic signed [PHW-1:0] phi_d [4], phi_q [4];
  logic signed [SW-1:0]  s1_q [4];
  logic signed [XW-1:0]  d1a_q;
  logic signed [AW-1:0]  da_q;
  logic [KIND_W-1:0]     k1_q;
  // Stage 2: weighted terms and area magnitude
  logic signed [MW-1:0]  w_d [4], w_q [4];
  logic signed [AW-1:0]  dsel;
  logic [AW-1:0]         amag_d, amag_q;
  logic                  aneg_q, dz_q;
  logic signed [AW-1:0]  d2b_q;
  logic signed [SW-1:0]  s2_q [2];
  logic [KIND_W-1:0]     k2_q;
  // Stage 3
  wsum_t   o_d, o_q;
  logic    asat;
  status_e st;

  assign en[3] = out_ready_i;
  assign en[2] = !v_q[2] || en[3];
  assign en[1] = !v_q[1] || en[2];
  assign en[0] = !v_q[0] || en[1];
  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[2];
  assign out_o       = o_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      if (en[1]) v_q[1] <= v_q[0];
      if (en[2]) v_q[2] <= v_q[1];
    end
  end

  // Each area operand is split into an unsigned low and a signed high slice
  always_comb begin
    s_in[0] = in_i.sx1;  dd_in[0] = in_i.d1;
    s_in[1] = in_i.sx2;  dd_in[1] = in_i.d2;
    s_in[2] = in_i.sy1;  dd_in[2] = in_i.d1;
    s_in[3] = in_i.sy2;  dd_in[3] = in_i.d2;
    for (int k = 0; k < 4; k++) begin
      plo_d[k] = PLW'(s_in[k]) * PLW'($signed({1'b0, dd_in[k][LOW-1:0]}));
      phi_d[k] = PHW'(s_in[k]) * PHW'($signed(dd_in[k][XW-1:LOW]));
    end
  end

  // Recombine slices; halve the doubled area, rounding ties away from zero
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      w_d[k] = (MW'(phi_q[k]) <<< LOW) + MW'(plo_q[k]);
    end
    dsel   = (k1_q == KIND_TRI) ? AW'(d1a_q) : da_q;
    amag_d = (dsel[AW-1] ? (~dsel + AW'(2)) : (dsel + AW'(1))) >> 1;
  end

  // Final sums, kind select, area saturation and status
  always_comb begin
    unique case (k2_q)
      KIND_TRI:  st = ST_OK;
      KIND_QUAD: st = dz_q ? ST_DEGEN : ST_OK;
      default:   st = ST_BADKIND;
    endcase
    if (k2_q == KIND_TRI) begin
      o_d.nx  = NW'(s2_q[0]);
      o_d.ny  = NW'(s2_q[1]);
      o_d.den = EW'(VERT_DIV);
    end else begin
      o_d.nx  = NW'(w_q[0]) + NW'(w_q[1]);
      o_d.ny  = NW'(w_q[2]) + NW'(w_q[3]);
      o_d.den = (EW'(d2b_q) <<< 1) + EW'(d2b_q);
    end
    asat = aneg_q ? (amag_q > (AW'(AREA_MAX) + AW'(1))) : (amag_q > AW'(AREA_MAX));
    if (st != ST_OK)  o_d.side.area = '0;
    else if (asat)    o_d.side.area = aneg_q ? AREA_MIN : AREA_MAX;
    else if (aneg_q)  o_d.side.area = -amag_q[AREA_W-1:0];
    else              o_d.side.area = amag_q[AREA_W-1:0];
    o_d.side.status = st;
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      plo_q <= plo_d;
      phi_q <= phi_d;
      s1_q  <= s_in;
      d1a_q <= in_i.d1;
      da_q  <= AW'(in_i.d1) + AW'(in_i.d2);
      k1_q  <= in_i.kind;
    end
    if (en[1]) begin
      w_q    <= w_d;
      amag_q <= amag_d;
      aneg_q <= dsel[AW-1];
      dz_q   <= (da_q == '0);
      d2b_q  <= da_q;
      s2_q[0] <= s1_q[0];
      s2_q[1] <= s1_q[2];
      k2_q   <= k1_q;
    end
    if (en[2]) begin
      o_q <= o_d;
    end
  end

endmodule

// ===== design/mac_div.sv =====
// Pipelined restoring divider for both centroid lanes, one quotient bit per stage.
`timescale 1ns / 1ps
module mac_div import mac_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  wsum_t in_i,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output res_t  out_o
);

  typedef struct packed {
    logic [1:0][RW-1:0] r;
    logic [1:0][QB-1:0] q;
    logic [1:0]         neg;
    logic [1:0]         ovf;
    logic [DVW-1:0]     dv;
    side_t              side;
  } dstg_t;

  dstg_t      st_d [NS];
  dstg_t      st_q [NS];
  logic [NS-1:0] v_q;
  logic [NS:0]   en;
  logic          vo_q;
  res_t          o_d, o_q;

  // Ready ripples back through empty stages
  assign en[NS] = !vo_q || out_ready_i;
  for (genvar k = 0; k < NS; k++) begin : g_en
    assign en[k] = !v_q[k] || en[k+1];
  end
  assign in_ready_o  = en[0];
  assign out_valid_o = vo_q;
  assign out_o       = o_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q  <= '0;
      vo_q <= 1'b0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
      if (en[NS]) vo_q <= v_q[NS-1];
    end
  end

  // Stage 0: magnitudes and quotient sign
  logic signed [NW-1:0] nsel [2];
  logic [NW-1:0]        nabs [2];
  logic [EW-1:0]        dabs;
  always_comb begin
    nsel[0] = in_i.nx;
    nsel[1] = in_i.ny;
    dabs    = in_i.den[EW-1] ? -in_i.den : in_i.den;
    st_d[0] = '0;
    for (int l = 0; l < 2; l++) begin
      nabs[l]          = nsel[l][NW-1] ? -nsel[l] : nsel[l];
      st_d[0].r[l]     = RW'(nabs[l]);
      st_d[0].neg[l]   = nsel[l][NW-1] ^ in_i.den[EW-1];
    end
    st_d[0].dv   = DVW'(dabs);
    st_d[0].side = in_i.side;
  end

  // Stage 1: rounding offset, 2|n| + |d| over 2|d|
  always_comb begin
    st_d[1] = st_q[0];
    for (int l = 0; l < 2; l++) begin
      st_d[1].r[l] = (st_q[0].r[l] << 1) + RW'(st_q[0].dv);
    end
    st_d[1].dv = st_q[0].dv << 1;
  end

  // Stage 2: flag quotients too large for the resolved bits
  always_comb begin
    st_d[2] = st_q[1];
    for (int l = 0; l < 2; l++) begin
      st_d[2].ovf[l] = (st_q[1].r[l] >= (RW'(st_q[1].dv) << QB));
    end
  end

  // One quotient bit per stage, most significant first
  for (genvar k = 3; k < NS; k++) begin : g_bit
    localparam int B = NS - 1 - k;
    logic [RW-1:0] sub;
    always_comb begin
      sub     = RW'(st_q[k-1].dv) << B;
      st_d[k] = st_q[k-1];
      for (int l = 0; l < 2; l++) begin
        if (st_q[k-1].r[l] >= sub) begin
          st_d[k].r[l]    = st_q[k-1].r[l] - sub;
          st_d[k].q[l][B] = 1'b1;
        end
      end
    end
  end

  for (genvar k = 0; k < NS; k++) begin : g_reg
    always_ff @(posedge clk_i) begin
      if (en[k]) st_q[k] <= st_d[k];
    end
  end

  // Output stage: sign, saturation, and zero for failed items
  logic [CW-1:0] cen [2];
  logic          big [2];
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      big[l] = st_q[NS-1].ovf[l] ||
               (st_q[NS-1].neg[l] ? (st_q[NS-1].q[l] > (CEN_MAX + CW'(1)))
                                  : (st_q[NS-1].q[l] > CEN_MAX));
      if (st_q[NS-1].side.status != ST_OK) cen[l] = '0;
      else if (big[l])                     cen[l] = st_q[NS-1].neg[l] ? CEN_MIN : CEN_MAX;
      else if (st_q[NS-1].neg[l])          cen[l] = -st_q[NS-1].q[l];
      else                                 cen[l] = st_q[NS-1].q[l];
    end
    o_d.cx   = cen[0];
    o_d.cy   = cen[1];
    o_d.side = st_q[NS-1].side;
  end

  always_ff @(posedge clk_i) begin
    if (en[NS]) o_q <= o_d;
  end

endmodule

// ===== design/mesh_element_area_centroid_core.sv =====
// Top level of the mesh element area and centroid core.
//
// Input stream: one item per 2D element. s_axis_tuser carries the element
// kind (5 triangle, 9 quad); s_axis_tdata carries four vertices in signed
// Q16.16. Output stream: m_axis_tdata carries the Q32.32 signed area and the
// Q16.16 centroid; m_axis_tuser carries the status (0 ok, 1 unknown kind,
// 2 zero-area quad). Failed items report zero area and centroid.
// Items pass through the cross products, the weighted sums, the centroid
// divider (one quotient bit per stage, 32 bits) and the output register.
// Throughput is one item per clock while the receiver keeps up.
// Reset empties every stage; no results appear until new items arrive.
// When the receiver stalls, items keep entering until every stage up to
// the output register holds one; then s_axis_tready drops and all data
// is held in place, nothing lost or repeated.
`timescale 1ns / 1ps
module mesh_element_area_centroid_core import mac_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // vertex1_x, vertex1_y, vertex2_x, vertex2_y, vertex3_x, vertex3_y,
  // vertex4_x, vertex4_y
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // element_kind
  input  logic [KIND_W-1:0]     s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // signed_area, centroid_x, centroid_y
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // status
  output logic [1:0]            m_axis_tuser
);

  logic  g_valid, g_ready, w_valid, w_ready, d_valid, d_ready;
  geom_t g_data;
  wsum_t w_data;
  res_t  d_data, o_q;
  logic  mv_q;

  mac_geom u_geom (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .kind_i      (s_axis_tuser),
    .vtx_i       (s_axis_tdata),
    .out_valid_o (g_valid),
    .out_ready_i (g_ready),
    .out_o       (g_data)
  );

  mac_wmul u_wmul (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (g_valid),
    .in_ready_o  (g_ready),
    .in_i        (g_data),
    .out_valid_o (w_valid),
    .out_ready_i (w_ready),
    .out_o       (w_data)
  );

  mac_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (w_valid),
    .in_ready_o  (w_ready),
    .in_i        (w_data),
    .out_valid_o (d_valid),
    .out_ready_i (d_ready),
    .out_o       (d_data)
  );

  // Output register: load when empty or when the receiver takes the item
  assign d_ready = !mv_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mv_q <= 1'b0;
    end else if (d_ready) begin
      mv_q <= d_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (d_ready) o_q <= d_data;
  end

  assign m_axis_tvalid = mv_q;
  assign m_axis_tdata  = {o_q.cy, o_q.cx, o_q.side.area};
  assign m_axis_tuser  = o_q.side.status;

  // A failed item carries no area or centroid
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser != ST_OK)) |-> (m_axis_tdata == '0))
    else $error("failed item with nonzero payload");

  // The input only stalls when a finished item is waiting at the output
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with empty output");

  // A divider result taken into the output register shows up next cycle
  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (d_valid && d_ready) |=> m_axis_tvalid)
    else $error("result lost at output register");

endmodule
